[sv/ccrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-folded CRC string hash package
// Request types, hash constants and the CRC table function shared by the
// hash datapath and the top level.
// ----------------------------------------------------------------------------
package ccrc_pkg;

  localparam int unsigned HashWidth = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [HashWidth-1:0] HashPoly   = 32'h04C1_1DB7;
  localparam logic [HashWidth-1:0] HashTopBit = 32'h8000_0000;
  localparam logic [HashWidth-1:0] HashLow24  = 32'h00FF_FFFF;
  localparam logic [HashWidth-1:0] HashInit   = 32'h0000_0000;

  localparam logic [ByteWidth-1:0] LowerA    = 8'h61;
  localparam logic [ByteWidth-1:0] LowerZ    = 8'h7A;
  localparam logic [ByteWidth-1:0] CaseDelta = 8'h20;
  localparam logic [ByteWidth-1:0] HighByte  = 8'h00;

  typedef struct packed {
    logic [ByteWidth-1:0] char_byte;
    logic                 is_last;
  } in_req_t;

  typedef struct packed {
    logic [HashWidth-1:0] hash_value;
    logic                 is_final;
  } out_req_t;

  // Entry of the 256-entry MSB-first CRC table for one index.
  function automatic logic [HashWidth-1:0] crc_table(input logic [ByteWidth-1:0] idx);
    logic [HashWidth-1:0] v;
    v = {idx, {(HashWidth-ByteWidth){1'b0}}};
    for (int k = 0; k < ByteWidth; k++) begin
      if ((v & HashTopBit) != '0) begin
        v = {v[HashWidth-2:0], 1'b0} ^ HashPoly;
      end else begin
        v = {v[HashWidth-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  // One right-shifting table update of the running hash.
  function automatic logic [HashWidth-1:0] hash_step(input logic [HashWidth-1:0] h,
                                                    input logic [ByteWidth-1:0] b);
    return ((h >> ByteWidth) & HashLow24) ^ crc_table(h[ByteWidth-1:0] ^ b);
  endfunction

endpackage

[sv/ccrc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-folded CRC hash datapath
// Upper-cases one byte and applies the two table updates for a 16-bit
// character whose upper half is zero.
// ----------------------------------------------------------------------------
module ccrc_datapath (
  input  logic [ccrc_pkg::HashWidth-1:0] hash_i,
  input  logic [ccrc_pkg::ByteWidth-1:0] char_byte_i,
  output logic [ccrc_pkg::HashWidth-1:0] hash_o
);

  logic [ccrc_pkg::ByteWidth-1:0] folded;
  logic [ccrc_pkg::HashWidth-1:0] low_hash;

  // Only ASCII lower-case letters are folded.
  always_comb begin
    if (char_byte_i >= ccrc_pkg::LowerA && char_byte_i <= ccrc_pkg::LowerZ) begin
      folded = char_byte_i - ccrc_pkg::CaseDelta;
    end else begin
      folded = char_byte_i;
    end
  end

  assign low_hash = ccrc_pkg::hash_step(hash_i, folded);
  assign hash_o   = ccrc_pkg::hash_step(low_hash, ccrc_pkg::HighByte);

endmodule

[sv/case_folded_crc32_string_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-folded CRC32 string hash
// Streams a name string one byte per request and returns the running hash
// after every byte, with the final hash flagged on the last byte.
// ----------------------------------------------------------------------------
// Each request carries one byte and a last-byte flag. The byte is upper-cased
// (ASCII a-z only) and the running 32-bit hash is updated twice, with the byte
// and with a zero byte, through the MSB-first table of polynomial 0x04C11DB7.
// Every request produces exactly one result request; the hash restarts from
// zero after a last byte. A request passes through the input register and
// then sits in the output register until taken. The block sustains one
// request per clock while the output is not stalled. Two chained table
// lookups lie between the input register and the running hash.
// An empty string is never streamed; its hash is zero.
// ----------------------------------------------------------------------------
module case_folded_crc32_string_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ccrc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ccrc_pkg::out_req_t out_req_o
);

  // Input register.
  logic              in_valid_q;
  ccrc_pkg::in_req_t in_req_q;

  // Running hash between strings and result register.
  logic [ccrc_pkg::HashWidth-1:0] running_hash_q, running_hash_d;
  logic                           out_valid_q;
  ccrc_pkg::out_req_t             out_req_q;

  logic [ccrc_pkg::HashWidth-1:0] next_hash;
  logic                           advance;
  logic                           in_fire;

  // The input register drains whenever the result register is empty or is
  // being taken in this cycle, so a full pipe still moves one per clock.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  ccrc_datapath u_datapath (
    .hash_i      (running_hash_q),
    .char_byte_i (in_req_q.char_byte),
    .hash_o      (next_hash)
  );

  // After a last byte the hash starts the next string from zero.
  always_comb begin
    running_hash_d = running_hash_q;
    if (advance) begin
      running_hash_d = in_req_q.is_last ? ccrc_pkg::HashInit : next_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      running_hash_q <= ccrc_pkg::HashInit;
    end else begin
      running_hash_q <= running_hash_d;
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_req_q.hash_value <= next_hash;
      out_req_q.is_final   <= in_req_q.is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

`ifndef SYNTHESIS
  // A last byte leaves the running hash at zero for the next string.
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_req_q.is_last) |=> (running_hash_q == ccrc_pkg::HashInit))
    else $error("running hash not cleared after last byte");

  // A request moved into the result register is presented with its hash.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && out_req_o.hash_value == $past(next_hash)))
    else $error("result register not loaded on advance");

  // The input side only stalls while a request is held in the input register.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held request");

  // The running hash changes only when a request advances.
  a_hash_moves_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(running_hash_q))
    else $error("running hash changed without an advancing request");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-folded CRC32 string hash testbench
// Streams name strings into the hash block, one byte per request, and checks
// every result request against a behavioral hash model kept in lockstep.
// ----------------------------------------------------------------------------
// A short table of directed bytes comes first. It covers the case-fold
// boundaries, zero bytes inside a string, non-ASCII bytes and single-byte
// strings. Random strings follow, mostly letters with some raw bytes mixed
// in. Both sides idle in random bursts, and the closing stretch runs at full
// rate. Inputs change on the falling edge, and both handshakes are sampled on
// the rising edge.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumRandomBytes = 1530;
  localparam int unsigned QuietTail      = 200;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned NumDirected    = 20;

  // One row of the directed table. Where hash_known is set, the expected
  // hash is typed in. Otherwise the hash model supplies it.
  typedef struct packed {
    logic [ccrc_pkg::ByteWidth-1:0] char_byte;
    logic                           is_last;
    logic                           hash_known;
    logic [ccrc_pkg::HashWidth-1:0] hash_value;
  } byte_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ccrc_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ccrc_pkg::out_req_t out_req_o;

  // The driver sets these on the falling edge together with the request, so
  // they are stable when the monitor samples the accepting edge.
  logic                           cur_known;
  logic [ccrc_pkg::HashWidth-1:0] cur_known_hash;

  logic                           quiet_tail;
  logic [ccrc_pkg::HashWidth-1:0] running_hash;
  ccrc_pkg::out_req_t             pending_hashes [$];
  int unsigned                    error_count;
  int unsigned                    bytes_sent;
  int unsigned                    strings_sent;
  int unsigned                    finals_checked;
  int unsigned                    results_checked;
  int unsigned                    stall_cycles;

  // The first row is a lone zero byte straight after reset. Both updates see
  // a zero index into the table, so its hash is zero.
  byte_row_t directed_rows [NumDirected] = '{
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{8'h61, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b0, 1'b0, 32'h0},
    '{8'h7A, 1'b1, 1'b0, 32'h0},
    '{8'h41, 1'b0, 1'b0, 32'h0},
    '{8'h42, 1'b0, 1'b0, 32'h0},
    '{8'h5A, 1'b1, 1'b0, 32'h0},
    '{8'h60, 1'b0, 1'b0, 32'h0},
    '{8'h7B, 1'b0, 1'b0, 32'h0},
    '{8'h40, 1'b0, 1'b0, 32'h0},
    '{8'h5B, 1'b1, 1'b0, 32'h0},
    '{8'h80, 1'b0, 1'b0, 32'h0},
    '{8'hE1, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    '{8'h78, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h79, 1'b1, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    '{8'h7F, 1'b0, 1'b0, 32'h0},
    '{8'h20, 1'b1, 1'b0, 32'h0}
  };

  case_folded_crc32_string_hash dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Only lowercase ASCII letters are folded. The neighbors of 'a' and 'z'
  // and every byte from 0x80 upward pass through unchanged.
  function automatic logic [ccrc_pkg::ByteWidth-1:0] upper_case(
      input logic [ccrc_pkg::ByteWidth-1:0] b);
    if (b >= ccrc_pkg::LowerA && b <= ccrc_pkg::LowerZ) begin
      return b - ccrc_pkg::CaseDelta;
    end
    return b;
  endfunction

  // Table entry for one index: the index sits in the top byte and is shifted
  // left eight times, folding in the polynomial whenever a one drops out.
  function automatic logic [ccrc_pkg::HashWidth-1:0] poly_entry(
      input logic [ccrc_pkg::ByteWidth-1:0] idx);
    logic [ccrc_pkg::HashWidth-1:0] acc;
    acc = {idx, 24'h00_0000};
    for (int k = 0; k < ccrc_pkg::ByteWidth; k++) begin
      if (acc[ccrc_pkg::HashWidth-1]) begin
        acc = {acc[ccrc_pkg::HashWidth-2:0], 1'b0} ^ ccrc_pkg::HashPoly;
      end else begin
        acc = {acc[ccrc_pkg::HashWidth-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic logic [ccrc_pkg::HashWidth-1:0] absorb_byte(
      input logic [ccrc_pkg::HashWidth-1:0] h,
      input logic [ccrc_pkg::ByteWidth-1:0] b);
    return {8'h00, h[ccrc_pkg::HashWidth-1:ccrc_pkg::ByteWidth]}
           ^ poly_entry(h[ccrc_pkg::ByteWidth-1:0] ^ b);
  endfunction

  // A character is two bytes wide: the folded byte, then a zero upper half.
  function automatic logic [ccrc_pkg::HashWidth-1:0] absorb_char(
      input logic [ccrc_pkg::HashWidth-1:0] h,
      input logic [ccrc_pkg::ByteWidth-1:0] b);
    return absorb_byte(absorb_byte(h, upper_case(b)), ccrc_pkg::HighByte);
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [ccrc_pkg::HashWidth-1:0] want,
                                 input logic [ccrc_pkg::HashWidth-1:0] got);
    $display("ERROR at %0t: %s expected %08h got %08h", $realtime, what, want, got);
    error_count++;
  endtask

  // Sends one byte request. Unless the closing stretch has begun, a random
  // idle burst may come first. The task returns at the accepting edge.
  task automatic send_byte(input logic [ccrc_pkg::ByteWidth-1:0] b, input logic last,
                           input logic known,
                           input logic [ccrc_pkg::HashWidth-1:0] known_hash);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    in_req_i.char_byte <= b;
    in_req_i.is_last   <= last;
    cur_known          <= known;
    cur_known_hash     <= known_hash;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (last) begin
      strings_sent++;
    end
  endtask

  // Random byte: four in ten are lowercase letters, so that folding is exercised
  // heavily. Two in ten come as uppercase letters and the rest as raw bytes.
  function automatic logic [ccrc_pkg::ByteWidth-1:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return ccrc_pkg::LowerA + 8'($urandom_range(0, 25));
    end else if (pick < 6) begin
      return 8'h41 + 8'($urandom_range(0, 25));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: random stall bursts with calm stretches in between. There is
  // no stall at all once the closing stretch has begun.
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail || burst == 0) begin
        out_stall_i <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          burst = $urandom_range(1, 13);
        end
      end else begin
        out_stall_i <= 1'b1;
        burst--;
      end
    end
  end

  // Monitor. An accepted byte advances the hash model and queues its
  // expected result. An accepted result is checked against the oldest entry.
  // The watchdog counts cycles in which neither side moves.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [ccrc_pkg::HashWidth-1:0] next_hash;
    ccrc_pkg::out_req_t             want;
    logic                           moved;
    if (!rst_ni) begin
      running_hash <= ccrc_pkg::HashInit;
      stall_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        moved     = 1'b1;
        next_hash = absorb_char(running_hash, in_req_i.char_byte);
        if (cur_known) begin
          pending_hashes.push_back('{hash_value: cur_known_hash, is_final: in_req_i.is_last});
        end else begin
          pending_hashes.push_back('{hash_value: next_hash, is_final: in_req_i.is_last});
        end
        running_hash <= in_req_i.is_last ? ccrc_pkg::HashInit : next_hash;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_hashes.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_req_o.hash_value);
        end else begin
          want = pending_hashes.pop_front();
          results_checked++;
          if (out_req_o.hash_value !== want.hash_value) begin
            report_mismatch("hash_value", want.hash_value, out_req_o.hash_value);
          end
          if (out_req_o.is_final !== want.is_final) begin
            report_mismatch("is_final", 32'(want.is_final), 32'(out_req_o.is_final));
          end
          if (want.is_final) begin
            finals_checked++;
          end
        end
      end
      if (moved) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("ERROR: no request accepted for %0d cycles", StallLimit);
        $display("case_folded_crc32_string_hash: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned remaining;
    int unsigned str_len;
    logic        last;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    cur_known       = 1'b0;
    cur_known_hash  = '0;
    quiet_tail      = 1'b0;
    error_count     = 0;
    bytes_sent      = 0;
    strings_sent    = 0;
    finals_checked  = 0;
    results_checked = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].char_byte, directed_rows[i].is_last,
                directed_rows[i].hash_known, directed_rows[i].hash_value);
    end

    // Random strings of 1 to 16 bytes. Now and then a long one is sent, so
    // that the hash runs for many rounds before it is cleared.
    remaining = NumRandomBytes;
    while (remaining > 0) begin
      str_len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int k = 0; k < str_len && remaining > 0; k++) begin
        if (remaining <= QuietTail) begin
          quiet_tail = 1'b1;
        end
        last = (k == str_len - 1) || (remaining == 1);
        send_byte(random_byte(), last, 1'b0, '0);
        remaining--;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_hashes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them final.",
             bytes_sent, strings_sent, results_checked, finals_checked);
    if (error_count == 0) begin
      $display("case_folded_crc32_string_hash: match");
    end else begin
      $display("Found %0d mismatches.", error_count);
      $display("case_folded_crc32_string_hash: mismatch");
    end
    $finish;
  end

endmodule
